// File: rtl/biq_pkg.sv
package biq_pkg;

    // default widths of the sample and coefficient words
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 18;

    // coefficient register file
    localparam int NUM_COEFS = 5;

    typedef logic [2:0] coef_idx_t;

    localparam coef_idx_t COEF_A0 = 3'd0;
    localparam coef_idx_t COEF_A1 = 3'd1;
    localparam coef_idx_t COEF_A2 = 3'd2;
    localparam coef_idx_t COEF_B1 = 3'd3;
    localparam coef_idx_t COEF_B2 = 3'd4;

    // microprogram length and step counter
    localparam int STEP_W    = 3;
    localparam int NUM_STEPS = 6;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t FIRST_STEP = step_t'(0);
    localparam step_t LAST_STEP  = step_t'(NUM_STEPS - 1);

    // multiplier sample-side operand
    typedef enum logic [1:0] {
        MA_IN,
        MA_X,
        MA_Y
    } mul_src_t;

    // adder operand that the product is added to or taken from
    typedef enum logic [1:0] {
        AA_D1,
        AA_D2,
        AA_ACC
    } add_src_t;

    // second delay update
    typedef enum logic [1:0] {
        D2_HOLD,
        D2_SUM,
        D2_PROD
    } d2_op_t;

    // condition that holds the sequencer on its current step
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_t;

    typedef struct packed {
        wait_t     wait_on;
        mul_src_t  mul_src;
        coef_idx_t coef_sel;
        logic      p_we;
        add_src_t  add_src;
        logic      add_sub;
        logic      acc_we;
        logic      y_we;
        logic      d1_we;
        d2_op_t    d2_op;
        logic      out_we;
        logic      last;
    } ucode_t;

    // control store, one word per step
    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w = '0;
        case (s)
            step_t'(0): begin
                // p = x * a0, word taken from the input
                w.wait_on  = WAIT_IN;
                w.mul_src  = MA_IN;
                w.coef_sel = COEF_A0;
                w.p_we     = 1'b1;
            end
            step_t'(1): begin
                // acc = d1 + x*a0 ; p = x * a1
                w.mul_src  = MA_X;
                w.coef_sel = COEF_A1;
                w.p_we     = 1'b1;
                w.add_src  = AA_D1;
                w.acc_we   = 1'b1;
            end
            step_t'(2): begin
                // y = round/sat(acc) ; acc = d2 + x*a1 ; p = x * a2
                w.mul_src  = MA_X;
                w.coef_sel = COEF_A2;
                w.p_we     = 1'b1;
                w.add_src  = AA_D2;
                w.acc_we   = 1'b1;
                w.y_we     = 1'b1;
            end
            step_t'(3): begin
                // d2 parks x*a2 ; p = y * b1
                w.mul_src  = MA_Y;
                w.coef_sel = COEF_B1;
                w.p_we     = 1'b1;
                w.d2_op    = D2_PROD;
            end
            step_t'(4): begin
                // d1 = sat(acc - y*b1) ; p = y * b2
                w.mul_src  = MA_Y;
                w.coef_sel = COEF_B2;
                w.p_we     = 1'b1;
                w.add_src  = AA_ACC;
                w.add_sub  = 1'b1;
                w.d1_we    = 1'b1;
            end
            step_t'(5): begin
                // d2 = sat(x*a2 - y*b2) ; word out
                w.wait_on  = WAIT_OUT;
                w.add_src  = AA_D2;
                w.add_sub  = 1'b1;
                w.d2_op    = D2_SUM;
                w.out_we   = 1'b1;
                w.last     = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/biq_datapath.sv
module biq_datapath #(
    parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  biq_pkg::ucode_t                ctl,
    input  logic                           fire,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [COEF_WIDTH-1:0]   coefs [biq_pkg::NUM_COEFS],
    output logic signed [SAMPLE_WIDTH-1:0] y_out
);

    localparam int FRAC_W  = COEF_WIDTH - 2;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int DELAY_W = SAMPLE_WIDTH + COEF_WIDTH + 2;
    localparam int SUM_W   = DELAY_W + 2;

    localparam logic signed [SUM_W-1:0] D_MAX =
        {{(SUM_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] D_MIN =
        {{(SUM_W - DELAY_W + 1){1'b1}}, {(DELAY_W - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] Y_MAX =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] Y_MIN =
        {{(SUM_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W-1:0]       p_reg;
    logic signed [SUM_W-1:0]        acc_reg;
    logic signed [SUM_W-1:0]        add_a;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        rnd;
    logic signed [SUM_W-1:0]        quot;
    logic signed [DELAY_W-1:0]      sum_sat;
    logic signed [DELAY_W-1:0]      d1_reg;
    logic signed [DELAY_W-1:0]      d2_reg;

    // shared multiplier
    always_comb begin
        case (ctl.mul_src)
            biq_pkg::MA_IN: mul_a = sample_in;
            biq_pkg::MA_X:  mul_a = x_reg;
            biq_pkg::MA_Y:  mul_a = y_reg;
            default:        mul_a = x_reg;
        endcase
        case (ctl.coef_sel)
            biq_pkg::COEF_A0: mul_b = coefs[0];
            biq_pkg::COEF_A1: mul_b = coefs[1];
            biq_pkg::COEF_A2: mul_b = coefs[2];
            biq_pkg::COEF_B1: mul_b = coefs[3];
            biq_pkg::COEF_B2: mul_b = coefs[4];
            default:          mul_b = coefs[0];
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // shared adder with delay-width saturation
    always_comb begin
        case (ctl.add_src)
            biq_pkg::AA_D1:  add_a = SUM_W'(d1_reg);
            biq_pkg::AA_D2:  add_a = SUM_W'(d2_reg);
            biq_pkg::AA_ACC: add_a = acc_reg;
            default:         add_a = acc_reg;
        endcase
        if (ctl.add_sub) begin
            sum = add_a - SUM_W'(p_reg);
        end else begin
            sum = add_a + SUM_W'(p_reg);
        end
        if (sum > D_MAX) begin
            sum_sat = D_MAX[DELAY_W-1:0];
        end else if (sum < D_MIN) begin
            sum_sat = D_MIN[DELAY_W-1:0];
        end else begin
            sum_sat = sum[DELAY_W-1:0];
        end
    end

    // round half up, floor shift, saturate to sample width
    always_comb begin
        rnd  = acc_reg + ROUND_HALF;
        quot = rnd >>> FRAC_W;
        if (quot > Y_MAX) begin
            y_next = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (quot < Y_MIN) begin
            y_next = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y_next = quot[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (ctl.p_we) begin
                p_reg <= prod;
            end
            if (ctl.p_we && ctl.mul_src == biq_pkg::MA_IN) begin
                x_reg <= sample_in;
            end
            if (ctl.acc_we) begin
                acc_reg <= sum;
            end
            if (ctl.y_we) begin
                y_reg <= y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= '0;
            d2_reg <= '0;
        end else if (fire) begin
            if (ctl.d1_we) begin
                d1_reg <= sum_sat;
            end
            case (ctl.d2_op)
                biq_pkg::D2_SUM:  d2_reg <= sum_sat;
                biq_pkg::D2_PROD: d2_reg <= DELAY_W'(p_reg);
                default:          d2_reg <= d2_reg;
            endcase
        end
    end

    assign y_out = y_reg;

endmodule

// File: rtl/biquad_iir_filter.sv
// biquad_iir_filter: one second-order iir section, transposed direct form ii
//
// input channel s_valid / s_ready / s_sample_in: one signed audio word per
// handshake. result channel m_valid / m_ready / m_sample_out: one filtered
// word per input word, rounded half up and saturated to the sample width.
// coefficients a0 a1 a2 b1 b2 (signed q2.frac) are written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write them only while the
// filter is idle, the block does not enforce this. an index past b2 is ignored.
//
// a six-step microprogram drives one shared multiplier and one adder: a
// word is taken on step 0, steps 1 to 4 work through it, and the result lands
// in the output register when step 5 fires. the five products run back to
// back through the single multiplier, so a new word is taken only after the
// last one has left step 5. s_ready is high on step 0 only.
//
// reset clears both delay accumulators, restores the pass-through
// coefficients (a0 = 1.0, rest 0) and empties the output register.
// a stalled receiver holds the sequencer on its last step until the output
// register frees up; the next word is taken while a result is still waiting.
module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH = biq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = biq_pkg::COEF_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input word channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    // result word channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    // coefficient write port
    input  logic                           cfg_wr_en,
    input  biq_pkg::coef_idx_t             cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_wdata
);

    // 1.0 in q2.frac
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        {2'b01, {(COEF_WIDTH - 2){1'b0}}};

    biq_pkg::step_t  step_reg;
    biq_pkg::step_t  step_next;
    biq_pkg::ucode_t ctl;
    logic            fire;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_out;
    logic signed [COEF_WIDTH-1:0]   coef_reg [biq_pkg::NUM_COEFS];

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= COEF_ONE;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
            coef_reg[4] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                biq_pkg::COEF_A0: coef_reg[0] <= cfg_wdata;
                biq_pkg::COEF_A1: coef_reg[1] <= cfg_wdata;
                biq_pkg::COEF_A2: coef_reg[2] <= cfg_wdata;
                biq_pkg::COEF_B1: coef_reg[3] <= cfg_wdata;
                biq_pkg::COEF_B2: coef_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control store lookup for the current step
    assign ctl = biq_pkg::ucode_rom(step_reg);

    // a step runs unless it waits on a word in or on room in the output register
    always_comb begin
        case (ctl.wait_on)
            biq_pkg::WAIT_IN:  fire = s_valid;
            biq_pkg::WAIT_OUT: fire = !m_valid_reg || m_ready;
            default:           fire = 1'b1;
        endcase
    end

    // step counter: hold while waiting, wrap after the last step
    always_comb begin
        if (!fire) begin
            step_next = step_reg;
        end else if (ctl.last) begin
            step_next = biq_pkg::FIRST_STEP;
        end else begin
            step_next = step_reg + biq_pkg::step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= biq_pkg::FIRST_STEP;
        end else begin
            step_reg <= step_next;
        end
    end

    assign s_ready = (ctl.wait_on == biq_pkg::WAIT_IN);

    biq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .fire      (fire),
        .sample_in (s_sample_in),
        .coefs     (coef_reg),
        .y_out     (y_out)
    );

    // output register
    always_comb begin
        if (fire && ctl.out_we) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && ctl.out_we) begin
            m_sample_reg <= y_out;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

`ifndef SYNTH
    // a taken word always starts the arithmetic steps
    a_accept_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (step_reg == biq_pkg::step_t'(1)))
        else $error("sequencer did not advance after input word");

    // results only appear from the last step
    a_out_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (!$past(m_valid) || $past(m_ready))) |->
            ($past(step_reg) == biq_pkg::LAST_STEP))
        else $error("result word loaded outside the last step");

    // a stalled receiver freezes the sequencer on its last step
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == biq_pkg::LAST_STEP && m_valid && !m_ready) |=>
            (step_reg == biq_pkg::LAST_STEP))
        else $error("sequencer left last step while output stalled");

    // step counter stays inside the microprogram
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= biq_pkg::LAST_STEP)
        else $error("step counter out of program range");

    // input is taken only on the first step
    a_ready_first: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (step_reg == biq_pkg::FIRST_STEP))
        else $error("input ready outside the first step");
`endif

endmodule

// File: dv/tb_biquad_iir_filter.sv
`timescale 1ns / 1ps

module tb_biquad_iir_filter;

    // widths of the block as built with default parameters
    localparam int SW   = biq_pkg::SAMPLE_WIDTH_DEF;
    localparam int CW   = biq_pkg::COEF_WIDTH_DEF;
    localparam int FRAC = CW - 2;          // fraction bits of the q2 coefficients
    localparam int DW   = SW + CW + 2;     // width of the delay accumulators

    // settle margin waited out after the last owed result has come back
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;

    // random traffic shape: three idling profiles, a few coefficient sets each
    localparam int NUM_PROFILES = 3;
    localparam int SETS_PER_PROFILE = 5;
    localparam int WORDS_PER_SET = 62;

    typedef logic signed [SW-1:0] sample_t;
    typedef logic signed [CW-1:0] coef_t;

    // clock, reset and the block's ports
    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    sample_t s_sample_in;
    logic    m_valid;
    logic    m_ready;
    sample_t m_sample_out;
    logic    cfg_wr_en;
    biq_pkg::coef_idx_t cfg_index;
    logic [CW-1:0] cfg_wdata;

    // predictor state: coefficient file and the two delay accumulators
    coef_t  coef_file [biq_pkg::NUM_COEFS];
    longint delay_one;
    longint delay_two;

    // filtered words still owed by the block, oldest first
    sample_t filtered_q [$];

    int src_idle_pct;
    int sink_idle_pct;
    int error_count;

    biquad_iir_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    // clamp to a signed range of the given width
    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one step of the transposed direct form ii section; updates the delays
    function automatic sample_t biquad_step(input sample_t x);
        longint xs;
        longint acc;
        longint y;
        longint n1;
        longint n2;
        xs  = longint'(x);
        acc = xs * longint'(coef_file[biq_pkg::COEF_A0]) + delay_one;
        // round half up: add half an lsb, then floor shift
        y   = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        y   = clamp(y, SW);
        // feedback uses the rounded and saturated output word
        n1  = xs * longint'(coef_file[biq_pkg::COEF_A1]) + delay_two
              - longint'(coef_file[biq_pkg::COEF_B1]) * y;
        n2  = xs * longint'(coef_file[biq_pkg::COEF_A2])
              - longint'(coef_file[biq_pkg::COEF_B2]) * y;
        delay_one = clamp(n1, DW);
        delay_two = clamp(n2, DW);
        return sample_t'(y);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // receiver: random backpressure, one assignment per edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // result checker: compare every accepted word with the oldest prediction
    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %0d", m_sample_out));
            end else begin
                want = filtered_q.pop_front();
                if (m_sample_out !== want)
                    report_mismatch($sformatf("sample_out got %0d want %0d",
                                              m_sample_out, want));
            end
        end
    end

    // send one input word; called at a clock edge, returns at the accepting edge
    task automatic send_word(input sample_t x);
        // random gap before the word is offered
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!s_ready);
        filtered_q.push_back(biquad_step(x));
    endtask

    // stop offering words and wait until every owed result has come back
    task automatic drain;
        s_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write; the predictor follows at the same edge
    task automatic cfg_write(input biq_pkg::coef_idx_t idx, input coef_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        // indexes past b2 are dropped by the block
        if (idx < biq_pkg::NUM_COEFS) coef_file[idx] = value;
    endtask

    task automatic cfg_done;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // load a full coefficient set while the filter is idle
    task automatic program_filter(input coef_t a0, input coef_t a1, input coef_t a2,
                                  input coef_t b1, input coef_t b2);
        drain();
        cfg_write(biq_pkg::COEF_A0, a0);
        cfg_write(biq_pkg::COEF_A1, a1);
        cfg_write(biq_pkg::COEF_A2, a2);
        cfg_write(biq_pkg::COEF_B1, b1);
        cfg_write(biq_pkg::COEF_B2, b2);
        cfg_done();
    endtask

    // random sample word, biased toward the rails and small values
    function automatic sample_t rand_sample();
        case ($urandom_range(7))
            0:       return {1'b1, {(SW-1){1'b0}}};
            1:       return {1'b0, {(SW-1){1'b1}}};
            2:       return sample_t'($signed($urandom_range(512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // random coefficient: rails, zero, gentle values or anything at all
    function automatic coef_t rand_coef();
        case ($urandom_range(5))
            0:       return {1'b1, {(CW-1){1'b0}}};
            1:       return {1'b0, {(CW-1){1'b1}}};
            2:       return '0;
            3:       return coef_t'($signed($urandom_range(16384)) - 8192);
            default: return coef_t'($urandom);
        endcase
    endfunction

    // reset coefficients pass the word straight through
    task automatic test_passthrough;
        send_word({1'b1, {(SW-1){1'b0}}});
        send_word({1'b0, {(SW-1){1'b1}}});
        send_word('0);
        send_word(sample_t'(1));
        send_word('1);
        send_word(sample_t'(16'h5555));
        send_word(sample_t'(16'haaaa));
    endtask

    // output saturation at both rails and round-half-up on odd halves
    task automatic test_gain_limits;
        // a0 just under +2.0
        program_filter({1'b0, {(CW-1){1'b1}}}, '0, '0, '0, '0);
        send_word({1'b0, {(SW-1){1'b1}}});
        send_word({1'b1, {(SW-1){1'b0}}});
        send_word(sample_t'(20000));
        send_word(sample_t'(1));
        // a0 = -2.0, the most negative sample overflows upward
        program_filter({1'b1, {(CW-1){1'b0}}}, '0, '0, '0, '0);
        send_word({1'b1, {(SW-1){1'b0}}});
        send_word({1'b0, {(SW-1){1'b1}}});
        // a0 = 0.5: exact halves on both signs
        program_filter(coef_t'(1) <<< (FRAC - 1), '0, '0, '0, '0);
        send_word(sample_t'(1));
        send_word('1);
        send_word(sample_t'(3));
        send_word(sample_t'(-3));
    endtask

    // impulse through extreme feed-forward and feedback taps, then dead indexes
    task automatic test_feedback_paths;
        program_filter(coef_t'(1) <<< FRAC, {1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}},
                       {1'b1, {(CW-1){1'b0}}}, {1'b0, {(CW-1){1'b1}}});
        send_word({1'b0, {(SW-1){1'b1}}});
        repeat (4) send_word('0);
        // writes past b2 must leave the coefficient file alone
        drain();
        for (int i = biq_pkg::NUM_COEFS; i < (1 << $bits(biq_pkg::coef_idx_t)); i++)
            cfg_write(biq_pkg::coef_idx_t'(i), coef_t'($urandom));
        cfg_done();
        send_word({1'b1, {(SW-1){1'b0}}});
        send_word(rand_sample());
    endtask

    // random coefficient sets and words under each idling profile
    task automatic test_random_traffic;
        for (int p = 0; p < NUM_PROFILES; p++) begin
            case (p)
                0: begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 52;
                end
                1: begin
                    src_idle_pct  = 52;
                    sink_idle_pct = 31;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SETS_PER_PROFILE; s++) begin
                program_filter(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
                repeat (WORDS_PER_SET) send_word(rand_sample());
            end
        end
    endtask

    initial begin
        // every input known from time zero, reset held low before the tests start
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_sample_in   = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = biq_pkg::COEF_A0;
        cfg_wdata     = '0;
        error_count   = 0;
        src_idle_pct  = 31;
        sink_idle_pct = 52;
        // predictor starts from the pass-through state
        coef_file[biq_pkg::COEF_A0] = coef_t'(1) <<< FRAC;
        coef_file[biq_pkg::COEF_A1] = '0;
        coef_file[biq_pkg::COEF_A2] = '0;
        coef_file[biq_pkg::COEF_B1] = '0;
        coef_file[biq_pkg::COEF_B2] = '0;
        delay_one = 0;
        delay_two = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_gain_limits();
        test_feedback_paths();
        test_random_traffic();

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d result words never came", filtered_q.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/biq_pkg.sv
rtl/biq_datapath.sv
rtl/biquad_iir_filter.sv
dv/tb_biquad_iir_filter.sv
